// ===== sv/raid5_stripe_parity_writer_top_assert.svh =====
// Assertion helpers for the stripe parity writer checker.
`ifndef RAID5_STRIPE_PARITY_WRITER_TOP_ASSERT_SVH
`define RAID5_STRIPE_PARITY_WRITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define R5PW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stripe parity writer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define R5PW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stripe parity writer: next-cycle check failed");

`endif

// ===== sv/r5pw_pkg.sv =====
`default_nettype none

package r5pw_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 4096;
   localparam int NODES = 4;
   localparam int NODE_W = $clog2(NODES);
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_PARITY = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_IDLE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_XOR   = 2'd1,
      MEM_DRAIN = 2'd2
   } mem_op_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  node;
      logic [31:0] block_index;
      logic [11:0] byte_offset;
      logic [7:0]  byte_value;
      logic        block_end;
      logic        parity_pending;
      logic [31:0] data_blocks_written;
   } rsp_type;

   // Classified transaction handed from front to back.
   typedef struct packed {
      mem_op_type mem_op;
      rsp_type    rsp;
   } desc_type;

endpackage

`default_nettype wire

// ===== sv/r5pw_fifo.sv =====
`default_nettype none

module r5pw_fifo import r5pw_pkg::*; #(
   parameter int ADDR_W = $clog2(BLOCK_BYTES_DEFAULT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire desc_type          push_desc,
   input  wire logic [ADDR_W-1:0] push_addr,
   input  wire logic              pop,
   output logic                   full,
   output logic                   head_valid,
   output desc_type               head_desc,
   output logic [ADDR_W-1:0]      head_addr
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type          desc_mem_ff [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = desc_mem_ff[rd_ptr_ff];
   assign head_addr  = addr_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         desc_mem_ff[wr_ptr_ff] <= push_desc;
         addr_mem_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

`default_nettype wire

// ===== sv/r5pw_front.sv =====
`default_nettype none

module r5pw_front import r5pw_pkg::*; #(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT,
   localparam int OFF_W = $clog2(BLOCK_BYTES)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire req_type          req,
   output desc_type              desc,
   output logic [OFF_W-1:0]      addr
);

   localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(BLOCK_BYTES - 1);
   localparam logic [NODE_W-1:0] BIS_LAST  = NODE_W'(NODES - 1);
   localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

   logic [NODE_W-1:0] spn_ff, spn_in;
   logic [NODE_W-1:0] bis_ff, bis_in;
   logic [OFF_W-1:0]  fill_ff, fill_in;
   logic [31:0]       base_ff, base_in;
   logic              drain_active_ff, drain_active_in;
   logic [OFF_W-1:0]  drain_off_ff, drain_off_in;
   logic [31:0]       count_ff, count_in;

   logic [NODE_W-1:0] bis_cur;
   logic [NODE_W-1:0] bis_next;
   logic [NODE_W:0]   node_sum;
   logic [NODE_W:0]   node_mod;
   logic [OFF_W-1:0]  off_cur;
   logic [31:0]       off_wide;
   logic              blk_end;

   assign bis_cur  = (bis_ff >= BIS_LAST) ? '0 : bis_ff;
   assign bis_next = bis_cur + NODE_W'(1);
   // spn + 1 + bis stays below twice NODES, so one subtract wraps it
   assign node_sum = {1'b0, spn_ff} + (NODE_W + 1)'(1) + {1'b0, bis_cur};
   assign node_mod = (node_sum >= (NODE_W + 1)'(NODES)) ?
                     node_sum - (NODE_W + 1)'(NODES) : node_sum;
   assign off_cur  = req.operation ? drain_off_ff : fill_ff;
   assign off_wide = 32'(off_cur);

   always_comb begin
      spn_in          = spn_ff;
      bis_in          = bis_ff;
      fill_in         = fill_ff;
      base_in         = base_ff;
      drain_active_in = drain_active_ff;
      drain_off_in    = drain_off_ff;
      count_in        = count_ff;
      blk_end         = 1'b0;
      desc            = '0;
      desc.mem_op     = MEM_NONE;
      desc.rsp.kind   = KIND_IDLE;
      addr            = off_cur;

      if (!req.operation) begin
         if (drain_active_ff) begin
            desc.rsp.kind = KIND_REJECT;
         end else begin
            bis_in = bis_cur;
            if (fill_ff == '0 && count_ff != '1) begin
               count_in = count_ff + 32'd1;
            end
            blk_end = (fill_ff == OFF_LAST) || req.last_byte;
            if (blk_end) begin
               fill_in = '0;
               bis_in  = bis_next;
               if (bis_next >= BIS_LAST || req.last_byte) begin
                  drain_active_in = 1'b1;
                  drain_off_in    = '0;
               end
            end else begin
               fill_in = fill_ff + OFF_W'(1);
            end
            desc.mem_op          = MEM_XOR;
            desc.rsp.kind        = KIND_DATA;
            desc.rsp.node        = node_mod[1:0];
            desc.rsp.block_index = base_ff + 32'(bis_cur) + 32'd1;
            desc.rsp.byte_offset = off_wide[11:0];
            desc.rsp.byte_value  = req.data_byte;
            desc.rsp.block_end   = blk_end;
         end
      end else if (drain_active_ff) begin
         blk_end = (drain_off_ff == OFF_LAST);
         if (blk_end) begin
            drain_active_in = 1'b0;
            drain_off_in    = '0;
            spn_in          = (spn_ff == NODE_LAST) ? '0 : spn_ff + NODE_W'(1);
            base_in         = base_ff + 32'(NODES);
            bis_in          = '0;
            fill_in         = '0;
         end else begin
            drain_off_in = drain_off_ff + OFF_W'(1);
         end
         desc.mem_op          = MEM_DRAIN;
         desc.rsp.kind        = KIND_PARITY;
         desc.rsp.node        = spn_ff[1:0];
         desc.rsp.block_index = base_ff;
         desc.rsp.byte_offset = off_wide[11:0];
         desc.rsp.block_end   = blk_end;
      end

      desc.rsp.parity_pending      = drain_active_in;
      desc.rsp.data_blocks_written = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spn_ff          <= '0;
         bis_ff          <= '0;
         fill_ff         <= '0;
         base_ff         <= '0;
         drain_active_ff <= 1'b0;
         drain_off_ff    <= '0;
         count_ff        <= '0;
      end else if (take) begin
         spn_ff          <= spn_in;
         bis_ff          <= bis_in;
         fill_ff         <= fill_in;
         base_ff         <= base_in;
         drain_active_ff <= drain_active_in;
         drain_off_ff    <= drain_off_in;
         count_ff        <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/r5pw_back.sv =====
`default_nettype none

module r5pw_back import r5pw_pkg::*; #(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT,
   localparam int OFF_W = $clog2(BLOCK_BYTES)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire desc_type         head_desc,
   input  wire logic [OFF_W-1:0] head_addr,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_BYTES - 1);

   logic [7:0]       mem [BLOCK_BYTES];

   logic             clr_active_ff, clr_active_in;
   logic [OFF_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic             s1_valid_ff, s1_valid_in;
   desc_type         s1_desc_ff;
   logic [OFF_W-1:0] s1_addr_ff;
   logic [7:0]       rd_raw_ff;
   logic             byp_hit_ff;
   logic [7:0]       byp_data_ff;

   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic             s1_adv;
   logic [7:0]       rd_data;
   logic             wr_en;
   logic [OFF_W-1:0] wr_addr;
   logic [7:0]       wr_data;

   assign clearing  = clr_active_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign s1_adv  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign pop     = head_valid && !clr_active_ff && (!s1_valid_ff || s1_adv);
   // a write to the address being read in the same cycle is forwarded
   assign rd_data = byp_hit_ff ? byp_data_ff : rd_raw_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = 8'd0;
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (s1_adv) begin
         unique case (s1_desc_ff.mem_op)
            MEM_XOR: begin
               wr_en   = 1'b1;
               wr_data = rd_data ^ s1_desc_ff.rsp.byte_value;
            end
            MEM_DRAIN: begin
               wr_en = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + OFF_W'(1);
         if (clr_cnt_ff == OFF_LAST) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = s1_desc_ff.rsp;
      if (s1_desc_ff.mem_op == MEM_DRAIN) begin
         out_data_in.byte_value = rd_data;
      end
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (pop) begin
         rd_raw_ff   <= mem[head_addr];
         byp_hit_ff  <= wr_en && (wr_addr == head_addr);
         byp_data_ff <= wr_data;
         s1_desc_ff  <= head_desc;
         s1_addr_ff  <= head_addr;
      end
      if (s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/raid5_stripe_parity_writer_top.sv =====
// Stripe parity writer with rotating parity.
// req channel: one transaction per byte of the file (operation 0) or per drain
//   tick (operation 1). Every request gives exactly one response, in order.
// rsp channel: data writes pass straight through tagged with node, block index
//   and offset; once a stripe closes, each drain tick returns one parity byte and
//   data requests are answered as rejected until the parity block is drained.
// Throughput: one request per cycle unless stalled; the parity store does one
//   read-modify-write per cycle through a registered read with write forwarding.
// Response path: a taken request is registered in the queue, then in the memory
//   read stage, then in the output register that drives rsp_valid.
// A four-entry queue separates the classifying front from the memory back end,
//   so req keeps flowing while rsp_stall is high until the queue fills; then
//   req_stall rises. A stalled response holds its value.
// Reset: all stripe state clears, then the parity store is swept to zero over
//   all BLOCK_BYTES addresses (4096 by default) with req_stall held high.
`default_nettype none

module raid5_stripe_parity_writer_top import r5pw_pkg::*; #(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int OFF_W = $clog2(BLOCK_BYTES);

   logic             take;
   desc_type         push_desc;
   logic [OFF_W-1:0] push_addr;
   logic             fifo_full;
   logic             head_valid;
   desc_type         head_desc;
   logic [OFF_W-1:0] head_addr;
   logic             pop;
   logic             clearing;

   assign req_stall = fifo_full || clearing;
   assign take      = req_valid && !req_stall;

   r5pw_front #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .desc  (push_desc),
      .addr  (push_addr)
   );

   r5pw_fifo #(
      .ADDR_W(OFF_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_desc  (push_desc),
      .push_addr  (push_addr),
      .pop        (pop),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_addr  (head_addr)
   );

   r5pw_back #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_addr  (head_addr),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/r5pw_checker.sv =====
`default_nettype none

`include "raid5_stripe_parity_writer_top_assert.svh"

module r5pw_checker import r5pw_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic rsp_held;
   logic parity_last;
   logic reject_out;
   logic reject_ok;
   logic idle_out;
   logic idle_ok;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign parity_last = rsp_valid && rsp_data.kind == KIND_PARITY && rsp_data.block_end;
   assign reject_out  = rsp_valid && rsp_data.kind == KIND_REJECT;
   assign reject_ok   = rsp_data.parity_pending && !rsp_data.block_end &&
                        rsp_data.block_index == 32'd0;
   assign idle_out    = rsp_valid && rsp_data.kind == KIND_IDLE;
   assign idle_ok     = !rsp_data.parity_pending && rsp_data.byte_value == 8'd0;

   // held response must not change
   `R5PW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // store sweep keeps the input closed straight after reset
   `R5PW_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, req_stall && !rsp_valid)

   `R5PW_ASSERT_NOW(a_last_parity, clock, reset, parity_last, !rsp_data.parity_pending)

   `R5PW_ASSERT_NOW(a_reject, clock, reset, reject_out, reject_ok)

   `R5PW_ASSERT_NOW(a_idle, clock, reset, idle_out, idle_ok)

endmodule

bind raid5_stripe_parity_writer_top r5pw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
